// ----- design/mosf_pkg.sv -----
package mosf_pkg;

  localparam int LEVEL_W  = 23;
  localparam int TENTHS_W = 13;
  localparam int STEPS_W  = 15;
  localparam int CMD_W    = 2;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(6553600);
  localparam logic [STEPS_W-1:0] STEPS_MAX = STEPS_W'(32767);

  localparam int TICKS_PER_TENTH_DEF = 4;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SNEAK = 2'd2;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
    clamp_level = (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

endpackage

// ----- design/mosf_in_if.sv -----
interface mosf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [mosf_pkg::CMD_W-1:0]            cmd;
  logic [mosf_pkg::LEVEL_W-1:0]          background_level;
  logic [mosf_pkg::LEVEL_W-1:0]          manual_level_in;
  logic [mosf_pkg::TENTHS_W-1:0]         sneak_tenths;

  modport source(output valid, cmd, background_level, manual_level_in, sneak_tenths,
                 input ready);
  modport sink(input valid, cmd, background_level, manual_level_in, sneak_tenths,
               output ready);
endinterface

// ----- design/mosf_out_if.sv -----
interface mosf_out_if;
  logic                         valid;
  logic                         ready;
  logic [mosf_pkg::LEVEL_W-1:0] output_level;
  logic                         override_on;
  logic                         sneak_on;

  modport source(output valid, output_level, override_on, sneak_on, input ready);
  modport sink(input valid, output_level, override_on, sneak_on, output ready);
endinterface

// ----- design/manual_override_sneak_fade.sv -----
// Take, start-sneak and unused-code transactions are absorbed with no result.
// A tick that needs no step goes to ST_FIN, which loads the output register; a sneak
// step first runs a restoring divider in ST_DIV, one quotient bit per cycle for all
// LEVEL_W bits, then updates the level in ST_APPLY before ST_FIN. No new transaction
// is taken until ST_FIN has loaded the result. A full output register stalls the block.
// Synchronous reset clears the override, the sneak, the step count and the level.
module manual_override_sneak_fade #(
  parameter int TICKS_PER_TENTH = mosf_pkg::TICKS_PER_TENTH_DEF
) (
  input logic        clk,
  input logic        rst,
  mosf_in_if.sink    item,
  mosf_out_if.source result
);

  localparam int LEVEL_W  = mosf_pkg::LEVEL_W;
  localparam int STEPS_W  = mosf_pkg::STEPS_W;
  localparam int PROD_W   = mosf_pkg::TENTHS_W + $clog2(TICKS_PER_TENTH + 1) + 1;
  localparam int CNT_W    = $clog2(LEVEL_W);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]         state;
  logic [LEVEL_W-1:0] manual_level;
  logic               override_active;
  logic               sneak_active;
  logic [STEPS_W-1:0] steps_left;

  logic [LEVEL_W-1:0] pend_level;
  logic               dir_up;
  logic [LEVEL_W-1:0] dq;
  logic [STEPS_W-1:0] rem;
  logic [CNT_W-1:0]   cnt;

  logic               out_valid;
  logic [LEVEL_W-1:0] out_level;
  logic               out_override;
  logic               out_sneak;

  logic               accept;
  logic [LEVEL_W-1:0] bg_c;
  logic [PROD_W-1:0]  steps_prod;
  logic [STEPS_W-1:0] steps_sat;
  logic [STEPS_W:0]   trial;
  logic [STEPS_W:0]   trial_diff;
  logic               out_free;

  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign bg_c       = mosf_pkg::clamp_level(item.background_level);

  assign steps_prod = PROD_W'(item.sneak_tenths) * PROD_W'(TICKS_PER_TENTH);
  assign steps_sat  = (steps_prod > PROD_W'(mosf_pkg::STEPS_MAX)) ? mosf_pkg::STEPS_MAX
                                                                  : steps_prod[STEPS_W-1:0];

  // Restoring division step: the remainder stays below the divisor, so it fits
  // STEPS_W bits and the trial value one more.
  assign trial      = {rem, dq[LEVEL_W-1]};
  assign trial_diff = trial - {1'b0, steps_left};

  assign out_free = !out_valid || result.ready;

  assign result.valid        = out_valid;
  assign result.output_level = out_level;
  assign result.override_on  = out_override;
  assign result.sneak_on     = out_sneak;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      manual_level    <= '0;
      override_active <= 1'b0;
      sneak_active    <= 1'b0;
      steps_left      <= '0;
      out_valid       <= 1'b0;
    end else begin
      // In the final state the output register is reloaded instead of drained.
      if (out_valid && result.ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (item.cmd)
              mosf_pkg::CMD_TAKE: begin
                manual_level    <= mosf_pkg::clamp_level(item.manual_level_in);
                override_active <= 1'b1;
                sneak_active    <= 1'b0;
              end
              mosf_pkg::CMD_SNEAK: begin
                if (override_active) begin
                  override_active <= 1'b0;
                  sneak_active    <= 1'b1;
                  steps_left      <= steps_sat;
                end
              end
              mosf_pkg::CMD_TICK: begin
                if (override_active) begin
                  pend_level <= manual_level;
                  state      <= ST_FIN;
                end else if (!sneak_active) begin
                  pend_level <= bg_c;
                  state      <= ST_FIN;
                end else if (manual_level == bg_c) begin
                  sneak_active <= 1'b0;
                  pend_level   <= bg_c;
                  state        <= ST_FIN;
                end else if (steps_left == '0) begin
                  manual_level <= bg_c;
                  sneak_active <= 1'b0;
                  pend_level   <= bg_c;
                  state        <= ST_FIN;
                end else begin
                  dir_up <= (bg_c > manual_level);
                  dq     <= (bg_c > manual_level) ? (bg_c - manual_level)
                                                  : (manual_level - bg_c);
                  rem    <= '0;
                  cnt    <= '0;
                  state  <= ST_DIV;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV: begin
          if (!trial_diff[STEPS_W]) begin
            rem <= trial_diff[STEPS_W-1:0];
            dq  <= {dq[LEVEL_W-2:0], 1'b1};
          end else begin
            rem <= trial[STEPS_W-1:0];
            dq  <= {dq[LEVEL_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(LEVEL_W - 1)) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          // dq now holds the quotient of the difference over the steps left.
          if (dir_up) begin
            manual_level <= manual_level + dq;
            pend_level   <= manual_level + dq;
          end else begin
            manual_level <= manual_level - dq;
            pend_level   <= manual_level - dq;
          end
          steps_left <= steps_left - 1'b1;
          if (steps_left == STEPS_W'(1)) begin
            sneak_active <= 1'b0;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_level    <= pend_level;
            out_override <= override_active;
            out_sneak    <= sneak_active;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/manual_override_sneak_fade_tb.sv -----
`timescale 1ns / 100ps

module manual_override_sneak_fade_tb;

  localparam int LEVEL_W  = mosf_pkg::LEVEL_W;
  localparam int TENTHS_W = mosf_pkg::TENTHS_W;
  localparam int STEPS_W  = mosf_pkg::STEPS_W;
  localparam int CMD_W    = mosf_pkg::CMD_W;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = mosf_pkg::LEVEL_MAX;
  localparam logic [STEPS_W-1:0] STEPS_MAX = mosf_pkg::STEPS_MAX;

  localparam int TICKS = mosf_pkg::TICKS_PER_TENTH_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ROWS = 25;
  localparam int RANDOM_ITEMS = 1550;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [LEVEL_W-1:0]  bg;
    logic [LEVEL_W-1:0]  man;
    logic [TENTHS_W-1:0] tenths;
    logic                pinned;
    logic [LEVEL_W-1:0]  exp_level;
    logic                exp_ovr;
    logic                exp_snk;
  } fade_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               ovr;
    logic               snk;
  } level_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mosf_in_if  item_if ();
  mosf_out_if result_if ();

  manual_override_sneak_fade #(.TICKS_PER_TENTH(TICKS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  always #5 clk = ~clk;

  // Predictor state of the channel.
  logic [LEVEL_W-1:0] lvl_q = '0;
  logic               ovr_q = 1'b0;
  logic               snk_q = 1'b0;
  logic [STEPS_W-1:0] steps_q = '0;

  fade_item_t    stim_q[$];
  level_result_t level_expect_q[$];
  fade_item_t    cur_item;
  fade_item_t    directed_rows [ROWS];

  int planned_items = 0;
  int accepted_items = 0;
  int results_seen = 0;
  int fade_results = 0;
  int errors = 0;
  int idle_cycles = 0;
  logic calm;

  function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
    return (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

  // Advances the predicted channel by one transaction; returns 1 when a tick yields a level.
  function automatic bit fade_advance(input fade_item_t it, output level_result_t res);
    logic [LEVEL_W-1:0] bg;
    int unsigned steps;
    bg = sat_level(it.bg);
    res = '0;
    case (it.cmd)
      mosf_pkg::CMD_TAKE: begin
        lvl_q = sat_level(it.man);
        ovr_q = 1'b1;
        snk_q = 1'b0;
        return 1'b0;
      end
      mosf_pkg::CMD_SNEAK: begin
        if (ovr_q) begin
          steps = it.tenths * TICKS;
          ovr_q = 1'b0;
          snk_q = 1'b1;
          steps_q = (steps > STEPS_MAX) ? STEPS_MAX : STEPS_W'(steps);
        end
        return 1'b0;
      end
      mosf_pkg::CMD_TICK: begin
        res.level = bg;
        if (ovr_q) begin
          res.level = lvl_q;
        end else if (snk_q) begin
          if (lvl_q == bg) begin
            snk_q = 1'b0;
          end else if (steps_q == '0) begin
            lvl_q = bg;
            snk_q = 1'b0;
          end else begin
            if (bg > lvl_q) lvl_q = lvl_q + (bg - lvl_q) / steps_q;
            else lvl_q = lvl_q - (lvl_q - bg) / steps_q;
            res.level = lvl_q;
            steps_q = steps_q - 1'b1;
            if (steps_q == '0) snk_q = 1'b0;
          end
        end
        res.ovr = ovr_q;
        res.snk = snk_q;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_level();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) return '0;
    if (pick < 8) return LEVEL_MAX;
    if (pick < 10) return '1;
    if (pick < 18) return LEVEL_W'($urandom_range(8388607, 6553601));
    return LEVEL_W'($urandom_range(6553600));
  endfunction

  task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [LEVEL_W-1:0] bg,
                          input logic [LEVEL_W-1:0] man, input logic [TENTHS_W-1:0] tenths);
    fade_item_t it;
    it = '0;
    it.cmd = cmd;
    it.bg = bg;
    it.man = man;
    it.tenths = tenths;
    stim_q = {stim_q, it};
    if (cmd != CMD_UNUSED) planned_items++;
  endtask

  // A take, a short hold, a sneak and enough ticks to usually finish the fade.
  task automatic add_fade_sequence();
    logic [LEVEL_W-1:0]  start;
    logic [LEVEL_W-1:0]  bg;
    logic [TENTHS_W-1:0] tenths;
    int unsigned         pick;
    int unsigned         n_ticks;
    start = rand_level();
    add_item(mosf_pkg::CMD_TAKE, LEVEL_W'($urandom), start, TENTHS_W'($urandom));
    repeat ($urandom_range(2)) add_item(mosf_pkg::CMD_TICK, rand_level(), LEVEL_W'($urandom),
                                        TENTHS_W'($urandom));
    pick = $urandom_range(99);
    if (pick < 10) tenths = '0;
    else if (pick < 70) tenths = TENTHS_W'($urandom_range(10, 1));
    else if (pick < 92) tenths = TENTHS_W'($urandom_range(25, 11));
    else tenths = TENTHS_W'($urandom_range(8191));
    add_item(mosf_pkg::CMD_SNEAK, LEVEL_W'($urandom), LEVEL_W'($urandom), tenths);
    if (tenths <= 25) n_ticks = tenths * TICKS + $urandom_range(3);
    else n_ticks = $urandom_range(40, 1);
    bg = ($urandom_range(9) == 0) ? start : rand_level();
    repeat (n_ticks) begin
      if ($urandom_range(99) < 12) bg = rand_level();
      add_item(mosf_pkg::CMD_TICK, bg, LEVEL_W'($urandom), TENTHS_W'($urandom));
      // Now and then a fresh take cuts the fade short.
      if ($urandom_range(99) < 2) add_item(mosf_pkg::CMD_TAKE, LEVEL_W'($urandom),
                                           rand_level(), TENTHS_W'($urandom));
    end
  endtask

  task automatic add_noise();
    logic [CMD_W-1:0] cmd;
    cmd = CMD_W'($urandom_range(3));
    add_item(cmd, LEVEL_W'($urandom), LEVEL_W'($urandom), TENTHS_W'($urandom));
    if (cmd == mosf_pkg::CMD_SNEAK) planned_items--;
  endtask

  always @(posedge clk) begin : drive_and_check
    level_result_t got;
    level_result_t want;
    bit            moved;
    moved = 1'b0;
    if (rst) begin
      item_if.valid <= 1'b0;
      result_if.ready <= 1'b0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        moved = 1'b1;
        accepted_items++;
        if (fade_advance(cur_item, got)) begin
          if (cur_item.pinned) begin
            want.level = cur_item.exp_level;
            want.ovr = cur_item.exp_ovr;
            want.snk = cur_item.exp_snk;
          end else begin
            want = got;
          end
          if (want.snk) fade_results++;
          level_expect_q = {level_expect_q, want};
        end
      end
      if (result_if.valid && result_if.ready) begin
        moved = 1'b1;
        results_seen++;
        if (level_expect_q.size() == 0) begin
          $error("level result with no transaction waiting for it");
          errors++;
        end else begin
          want = level_expect_q.pop_front();
          if (result_if.output_level !== want.level) begin
            $error("output_level: expected %0d, got %0d", want.level, result_if.output_level);
            errors++;
          end
          if (result_if.override_on !== want.ovr) begin
            $error("override_on: expected %0b, got %0b", want.ovr, result_if.override_on);
            errors++;
          end
          if (result_if.sneak_on !== want.snk) begin
            $error("sneak_on: expected %0b, got %0b", want.snk, result_if.sneak_on);
            errors++;
          end
        end
      end
      calm = (accepted_items >= 700 && accepted_items < 1000);
      if (!item_if.valid || item_if.ready) begin
        if (stim_q.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
          cur_item <= stim_q[0];
          item_if.cmd <= stim_q[0].cmd;
          item_if.background_level <= stim_q[0].bg;
          item_if.manual_level_in <= stim_q[0].man;
          item_if.sneak_tenths <= stim_q[0].tenths;
          item_if.valid <= 1'b1;
          stim_q.pop_front();
        end else begin
          item_if.valid <= 1'b0;
        end
      end
      result_if.ready <= calm || ($urandom_range(99) >= 36);
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : run
    item_if.valid = 1'b0;
    item_if.cmd = mosf_pkg::CMD_TICK;
    item_if.background_level = '0;
    item_if.manual_level_in = '0;
    item_if.sneak_tenths = '0;
    result_if.ready = 1'b0;
    cur_item = '0;

    // cmd, background, manual, tenths, pinned, level, override, sneak
    directed_rows = '{
      '{mosf_pkg::CMD_TICK,  0,       0,       0,    1, 0,       0, 0},
      '{mosf_pkg::CMD_TICK,  8388607, 0,       0,    1, 6553600, 0, 0},
      '{mosf_pkg::CMD_TICK,  6553600, 0,       0,    1, 6553600, 0, 0},
      '{mosf_pkg::CMD_SNEAK, 0,       0,       5,    0, 0,       0, 0},
      '{CMD_UNUSED,          8388607, 8388607, 8191, 0, 0,       0, 0},
      '{mosf_pkg::CMD_TAKE,  0,       8388607, 0,    0, 0,       0, 0},
      '{mosf_pkg::CMD_TICK,  100,     0,       0,    1, 6553600, 1, 0},
      '{mosf_pkg::CMD_SNEAK, 0,       0,       1,    0, 0,       0, 0},
      '{mosf_pkg::CMD_TICK,  0,       0,       0,    0, 0,       0, 0},
      '{mosf_pkg::CMD_TICK,  0,       0,       0,    0, 0,       0, 0},
      '{mosf_pkg::CMD_TICK,  0,       0,       0,    0, 0,       0, 0},
      '{mosf_pkg::CMD_TICK,  0,       0,       0,    0, 0,       0, 0},
      '{mosf_pkg::CMD_TAKE,  0,       1000,    0,    0, 0,       0, 0},
      '{mosf_pkg::CMD_SNEAK, 0,       0,       0,    0, 0,       0, 0},
      '{mosf_pkg::CMD_TICK,  5000,    0,       0,    1, 5000,    0, 0},
      '{mosf_pkg::CMD_TAKE,  0,       777,     0,    0, 0,       0, 0},
      '{mosf_pkg::CMD_SNEAK, 0,       0,       8191, 0, 0,       0, 0},
      '{mosf_pkg::CMD_TICK,  777,     0,       0,    1, 777,     0, 0},
      '{mosf_pkg::CMD_TAKE,  0,       0,       0,    0, 0,       0, 0},
      '{mosf_pkg::CMD_SNEAK, 0,       0,       8191, 0, 0,       0, 0},
      '{mosf_pkg::CMD_TICK,  6553600, 0,       0,    0, 0,       0, 0},
      '{mosf_pkg::CMD_TAKE,  0,       5,       0,    0, 0,       0, 0},
      '{mosf_pkg::CMD_TICK,  9,       0,       0,    1, 5,       1, 0},
      '{mosf_pkg::CMD_SNEAK, 0,       0,       2,    0, 0,       0, 0},
      '{mosf_pkg::CMD_TICK,  3,       0,       0,    0, 0,       0, 0}
    };
    for (int i = 0; i < ROWS; i++) stim_q = {stim_q, directed_rows[i]};

    planned_items = 0;
    while (planned_items < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 80) add_fade_sequence();
      else repeat ($urandom_range(5, 1)) add_noise();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || item_if.valid) @(posedge clk);
    while (level_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Drove %0d transactions; checked %0d tick levels, %0d of them mid-fade.",
             accepted_items, results_seen, fade_results);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/mosf_pkg.sv
design/mosf_in_if.sv
design/mosf_out_if.sv
design/manual_override_sneak_fade.sv
tb/manual_override_sneak_fade_tb.sv
